[hdl/least_loaded_job_dispatcher_defines.svh]
// Assertion macros for the least-loaded job dispatcher.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LEAST_LOADED_JOB_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_JOB_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define LLJD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLJD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lljd_pkg.sv]
// Shared types and constants for the least-loaded job dispatcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package lljd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MACHINES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_TYPE_ZERO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COST_TYPE_ONE   = 2'd2;

  localparam logic [3:0] MACHINES_RST = 4'd5;
  localparam logic [7:0] COST0_RST    = 8'd10;
  localparam logic [7:0] COST1_RST    = 8'd20;

  typedef struct packed {
    logic [15:0] job_id;
    logic        job_type;
    logic [7:0]  job_weight;
  } in_item_t;

  typedef struct packed {
    logic [15:0] assigned_job;
    logic [2:0]  chosen_machine;
    logic [31:0] machine_busy_time;
    logic [23:0] machine_total_weight;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch job, start scan
    logic issue;   // read one machine entry
    logic update;  // write back chosen machine, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current read is the last active machine
    logic out_hold;   // result register full and stalled
  } sts_t;

endpackage

`default_nettype wire

[hdl/lljd_datapath.sv]
// Datapath: config registers, per-machine load store, min search, update.
// Depends on lljd_pkg.
`default_nettype none

module lljd_datapath #(
  parameter int MAX_MACHINES = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lljd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lljd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire lljd_pkg::in_item_t               in_data,
  input  wire lljd_pkg::cmd_t                   cmd,
  output lljd_pkg::sts_t                        sts,
  input  wire logic                             out_stall,
  output logic                                  out_valid,
  output lljd_pkg::out_item_t                   out_data
);
  import lljd_pkg::*;

  localparam int MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CW = $clog2(MAX_MACHINES + 1);

  logic [3:0]    machines_r;
  logic [7:0]    cost0_r, cost1_r;

  logic [15:0]   job_id_r;
  logic [7:0]    weight_r;
  logic [15:0]   prod_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] n_nxt;

  logic [MW-1:0] scan_idx_r;
  logic          rd_vld_r;
  logic [MW-1:0] rd_idx_r;
  logic [31:0]   rd_busy_r;
  logic [23:0]   rd_wgt_r;
  logic          rd_ent_vld_r;

  logic [MW-1:0] best_idx_r;
  logic [31:0]   best_busy_r;
  logic [23:0]   best_wgt_r;

  logic [31:0]   busy_mem [MAX_MACHINES];
  logic [23:0]   wgt_mem  [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] ent_vld_r;

  logic          out_valid_r;
  out_item_t     out_r;

  logic [31:0]   cand_busy;
  logic [23:0]   cand_wgt;
  logic          take;
  logic [32:0]   busy_sum;
  logic [24:0]   wgt_sum;
  logic [31:0]   busy_new;
  logic [23:0]   wgt_new;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machines_r <= MACHINES_RST;
      cost0_r    <= COST0_RST;
      cost1_r    <= COST1_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MACHINES_IN_USE: machines_r <= cfg_data[3:0];
        REG_COST_TYPE_ZERO:  cost0_r    <= cfg_data;
        REG_COST_TYPE_ONE:   cost1_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // active count, clamped to 1 .. MAX_MACHINES
  always_comb begin
    priority if (machines_r == 4'd0) begin
      n_nxt = CW'(1);
    end else if (int'(machines_r) > MAX_MACHINES) begin
      n_nxt = CW'(MAX_MACHINES);
    end else begin
      n_nxt = CW'(machines_r);
    end
  end

  // job capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      job_id_r <= in_data.job_id;
      weight_r <= in_data.job_weight;
      prod_r   <= 16'(in_data.job_weight) *
                  16'(in_data.job_type ? cost1_r : cost0_r);
      n_r      <= n_nxt;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.issue && !sts.scan_last) begin
        scan_idx_r <= scan_idx_r + MW'(1);
      end
    end
  end

  assign sts.scan_last = (scan_idx_r == MW'(n_r - CW'(1)));

  // load store; entry valid bits stand in for the reset clear
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      busy_mem[best_idx_r] <= busy_new;
      wgt_mem[best_idx_r]  <= wgt_new;
    end
    rd_busy_r    <= busy_mem[scan_idx_r];
    rd_wgt_r     <= wgt_mem[scan_idx_r];
    rd_ent_vld_r <= ent_vld_r[scan_idx_r];
    rd_idx_r     <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (cmd.update) begin
      ent_vld_r[best_idx_r] <= 1'b1;
    end
  end

  // running minimum; strict less-than keeps the lowest index on a tie
  assign cand_busy       = rd_ent_vld_r ? rd_busy_r : '0;
  assign cand_wgt        = rd_ent_vld_r ? rd_wgt_r : '0;
  assign take            = rd_vld_r && ((rd_idx_r == '0) || (cand_busy < best_busy_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= rd_idx_r;
      best_busy_r <= cand_busy;
      best_wgt_r  <= cand_wgt;
    end
  end

  // saturating accumulate
  assign busy_sum = {1'b0, best_busy_r} + 33'(prod_r);
  assign wgt_sum  = {1'b0, best_wgt_r} + 25'(weight_r);
  assign busy_new = busy_sum[32] ? '1 : busy_sum[31:0];
  assign wgt_new  = wgt_sum[24] ? '1 : wgt_sum[23:0];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.assigned_job         <= job_id_r;
      out_r.chosen_machine       <= 3'(best_idx_r);
      out_r.machine_busy_time    <= busy_new;
      out_r.machine_total_weight <= wgt_new;
    end
  end

  assign sts.out_hold = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

`default_nettype wire

[hdl/lljd_ctrl.sv]
// Controller: sequences accept, machine scan, compare drain and update.
// Depends on lljd_pkg.
`default_nettype none

module lljd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lljd_pkg::sts_t sts,
  output lljd_pkg::cmd_t      cmd
);
  import lljd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_UPD   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (sts.scan_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_UPD;
      S_UPD:   if (!sts.out_hold) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.issue  = (state_r == S_SCAN);
  assign cmd.update = (state_r == S_UPD) && !sts.out_hold;

endmodule

`default_nettype wire

[hdl/least_loaded_job_dispatcher.sv]
// Top level of the least-loaded job dispatcher.
// Depends on lljd_pkg, lljd_ctrl, lljd_datapath, least_loaded_job_dispatcher_defines.svh.
//
//  port group | direction | handshake          | payload
//  -----------+-----------+--------------------+---------------------------
//  in_        | input     | in_valid/in_stall  | in_data  (lljd_pkg::in_item_t)
//  out_       | output    | out_valid/out_stall| out_data (lljd_pkg::out_item_t)
//  cfg_       | input     | cfg_we             | cfg_index, cfg_data
//
// Each item passes through the accept cycle, one load-store read per active
// machine, a compare of the last read and an update. The single read port of
// the load store is why the machines are read one at a time.
// Reset (rst_n, synchronous) clears all loads and weights at once via entry
// valid bits and restores the register defaults; no clearing pass.
// in_stall is high from accept to update. A stalled result holds the update
// cycle only; the next item may already be accepted after it.
`default_nettype none

module least_loaded_job_dispatcher #(
  parameter int MAX_MACHINES = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lljd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lljd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire lljd_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output lljd_pkg::out_item_t                   out_data
);
  import lljd_pkg::*;

  `include "least_loaded_job_dispatcher_defines.svh"

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lljd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // load store, minimum search and saturating update
  lljd_datapath #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted item keeps the input side closed next cycle
  `LLJD_ASSERT_NEXT(a_busy_after_load, cmd.load, in_stall, "input not closed after accept")
  // update never overwrites a result still waiting
  `LLJD_ASSERT_NOW(a_no_overwrite, cmd.update, !(out_valid && out_stall), "result overwritten")
  // every update presents a result next cycle
  `LLJD_ASSERT_NEXT(a_result_follows, cmd.update, out_valid, "update without result")

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for least_loaded_job_dispatcher: directed and random jobs,
// register changes between phases, a run of largest-cost jobs on one machine.
// Depends on lljd_pkg and the RTL of the block only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lljd_pkg::*;

  localparam int MACHINE_SLOTS = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind it

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // Own copy of the block's registers and per-machine accumulators.
  logic [3:0] machines_setting = MACHINES_RST;
  logic [7:0] cost_zero = COST0_RST;
  logic [7:0] cost_one = COST1_RST;
  logic [31:0] busy_fifths[MACHINE_SLOTS] = '{default: '0};
  logic [23:0] total_weight[MACHINE_SLOTS] = '{default: '0};

  out_item_t expected_assignments[$];
  int error_count = 0;
  bit quiet = 1'b0;  // set: neither side idles

  least_loaded_job_dispatcher #(
    .MAX_MACHINES(MACHINE_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Idle with a chance of roughly 6 in a hundred, none while quiet.
  function automatic bit roll_idle();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  // Greedy choice: least busy active machine, lowest number on a tie.
  // Updates the local accumulators and returns the result item to expect.
  function automatic out_item_t assign_job(in_item_t job);
    int unsigned active;
    int unsigned best;
    logic [7:0] cost;
    logic [32:0] new_busy;
    logic [24:0] new_weight;
    out_item_t res;
    active = machines_setting;
    if (active < 1) active = 1;               // zero machines means machine 0 alone
    if (active > MACHINE_SLOTS) active = MACHINE_SLOTS;
    best = 0;
    for (int unsigned i = 1; i < active; i++) begin
      if (busy_fifths[i] < busy_fifths[best]) best = i;
    end
    cost = job.job_type ? cost_one : cost_zero;
    new_busy = {1'b0, busy_fifths[best]} + 33'(job.job_weight) * 33'(cost);
    busy_fifths[best] = new_busy[32] ? 32'hFFFF_FFFF : new_busy[31:0];
    new_weight = {1'b0, total_weight[best]} + 25'(job.job_weight);
    total_weight[best] = new_weight[24] ? 24'hFF_FFFF : new_weight[23:0];
    res.assigned_job = job.job_id;
    res.chosen_machine = best[2:0];
    res.machine_busy_time = busy_fifths[best];
    res.machine_total_weight = total_weight[best];
    return res;
  endfunction

  function automatic void flag_mismatch(string what, longint unsigned exp_v,
                                        longint unsigned act_v);
    error_count++;
    $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
  endfunction

  // Result side: random stall, and each accepted item checked against the
  // oldest expectation.
  always @(posedge clk) begin
    out_stall <= roll_idle();
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_assignments.size() == 0) begin
        flag_mismatch("unexpected result, assigned_job", 0, out_data.assigned_job);
      end else begin
        exp_item = expected_assignments.pop_front();
        if (out_data.assigned_job !== exp_item.assigned_job)
          flag_mismatch("assigned_job", exp_item.assigned_job, out_data.assigned_job);
        if (out_data.chosen_machine !== exp_item.chosen_machine)
          flag_mismatch("chosen_machine", exp_item.chosen_machine, out_data.chosen_machine);
        if (out_data.machine_busy_time !== exp_item.machine_busy_time)
          flag_mismatch("machine_busy_time", exp_item.machine_busy_time,
                        out_data.machine_busy_time);
        if (out_data.machine_total_weight !== exp_item.machine_total_weight)
          flag_mismatch("machine_total_weight", exp_item.machine_total_weight,
                        out_data.machine_total_weight);
      end
    end
  end

  // Sends one job item. in_valid is left high on return so that back-to-back
  // items need no second assignment in the same step; an idle cycle or
  // wait_idle lowers it.
  task automatic send_job(input logic [15:0] id, input logic kind, input logic [7:0] weight);
    in_item_t job;
    out_item_t exp_res;
    job.job_id = id;
    job.job_type = kind;
    job.job_weight = weight;
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = assign_job(job);
    expected_assignments.insert(expected_assignments.size(), exp_res);
  endtask

  // Every item yields a result, so an empty queue means the block is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_assignments.size() != 0) @(posedge clk);
  endtask

  // One write cycle, then one quiet cycle so that back-to-back writes never
  // drive cfg_we twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MACHINES_IN_USE: machines_setting = val[3:0];
      REG_COST_TYPE_ZERO:  cost_zero = val;
      REG_COST_TYPE_ONE:   cost_one = val;
      default: ;  // unknown index: ignored by the block too
    endcase
    @(posedge clk);
  endtask

  // Reset defaults: five machines, costs 10 and 20; zero weight and ties at zero.
  task automatic test_reset_defaults();
    send_job(16'h0000, 1'b0, 8'd0);    // zero weight: machine 0, nothing added
    send_job(16'hFFFF, 1'b1, 8'd255);  // all idle, lowest number wins
    send_job(16'h1234, 1'b0, 8'd1);
    send_job(16'hA5A5, 1'b1, 8'd128);
    send_job(16'h5A5A, 1'b0, 8'd200);
    send_job(16'h0F0F, 1'b1, 8'd3);
    send_job(16'hF0F0, 1'b0, 8'd7);    // back to the lightest machine
  endtask

  // Register extremes, unknown index, zero cost, machines dropped and restored.
  task automatic test_register_extremes();
    write_reg(REG_UNUSED, 8'hFF);
    send_job(16'h0001, 1'b1, 8'd10);       // still five machines, costs unchanged
    write_reg(REG_MACHINES_IN_USE, 8'hF0); // count of zero, machine 0 alone
    send_job(16'h0002, 1'b0, 8'd255);
    write_reg(REG_MACHINES_IN_USE, 8'h0F); // fifteen, clipped to eight
    send_job(16'h0003, 1'b1, 8'd255);
    send_job(16'h0004, 1'b0, 8'd17);
    write_reg(REG_COST_TYPE_ZERO, 8'h00);
    write_reg(REG_COST_TYPE_ONE, 8'hFF);
    send_job(16'h0005, 1'b0, 8'd255);      // zero cost: busy time unchanged
    send_job(16'h0006, 1'b1, 8'd255);
    write_reg(REG_MACHINES_IN_USE, 8'h02); // machines 2 and up left out
    send_job(16'h0007, 1'b1, 8'd40);
    send_job(16'h0008, 1'b1, 8'd40);
    write_reg(REG_MACHINES_IN_USE, 8'hF8); // all eight take part again
    send_job(16'h0009, 1'b1, 8'd1);
    send_job(16'h000A, 1'b0, 8'd99);
  endtask

  // Random phases, each under a fresh register setting.
  task automatic test_random_mix();
    logic [7:0] weight;
    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_MACHINES_IN_USE, 8'($urandom_range(255)));
      write_reg(REG_COST_TYPE_ZERO, ($urandom_range(3) == 0) ?
                ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255)));
      write_reg(REG_COST_TYPE_ONE, ($urandom_range(3) == 0) ?
                ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255)));
      quiet = (phase == 4);
      for (int n = 0; n < 140; n++) begin
        case ($urandom_range(9))
          0: weight = 8'd0;
          1: weight = 8'd255;
          default: weight = 8'($urandom_range(255));
        endcase
        send_job(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)), weight);
      end
    end
    quiet = 1'b0;
  endtask

  // One machine at the largest cost and weight: the largest step per job,
  // piled up on a single machine, then a zero-weight job and one more.
  task automatic test_heavy_load();
    write_reg(REG_MACHINES_IN_USE, 8'h01);
    write_reg(REG_COST_TYPE_ZERO, 8'hFF);
    write_reg(REG_COST_TYPE_ONE, 8'hFF);
    quiet = 1'b1;
    for (int n = 0; n < 60; n++)
      send_job(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)), 8'd255);
    quiet = 1'b0;
    send_job(16'hBEEF, 1'b0, 8'd0);
    send_job(16'hCAFE, 1'b1, 8'd255);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_mix();
    test_heavy_load();
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_assignments.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Slowest correct run is under a quarter of a millisecond; this is well beyond it.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/lljd_pkg.sv
hdl/lljd_datapath.sv
hdl/lljd_ctrl.sv
hdl/least_loaded_job_dispatcher.sv
test/tb.sv
